FILE: rtl/rpac_pkg.sv
package rpac_pkg;

  localparam int CORDIC_STAGES = 20;

  localparam int COORD_W    = 32;
  localparam int OFFSET_W   = COORD_W + 1;
  localparam int IN_DATA_W  = 5 * COORD_W;
  localparam int OUT_DATA_W = 2 * COORD_W;
  localparam int PROD_W     = OFFSET_W + COORD_W;
  localparam int DOT_W      = PROD_W + 1;
  localparam int ROT_W      = DOT_W - 30;

  // Phase scale factors: round(2^31/pi) and round(2^40/360)
  localparam logic [31:0] K_RAD = 32'd683565276;
  localparam logic [31:0] K_DEG = 32'd3054198966;

  localparam logic signed [31:0] CORDIC_X0  = 32'sd652032874;
  localparam logic [31:0]        PHASE_BIAS = 32'h2000_0000;
  localparam logic signed [DOT_W-1:0] ROUND_HALF = DOT_W'(64'h2000_0000);

  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Quarter-turn codes
  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  typedef struct packed {
    logic [1:0]                 quad;
    logic signed [OFFSET_W-1:0] dx;
    logic signed [OFFSET_W-1:0] dy;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
  } rpac_geo_t;

  typedef struct packed {
    logic                      ovf;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } rpac_res_t;

  // Clamp a 37-bit sum to 32 bits, flag when clamped
  function automatic logic [COORD_W:0] sat_coord(input logic signed [COORD_W+4:0] v);
    logic hi_ovf;
    logic lo_ovf;
    hi_ovf = !v[COORD_W+4] && (|v[COORD_W+3:COORD_W-1]);
    lo_ovf = v[COORD_W+4] && !(&v[COORD_W+3:COORD_W-1]);
    if (hi_ovf) begin
      sat_coord = {1'b1, SAT_MAX};
    end else if (lo_ovf) begin
      sat_coord = {1'b1, SAT_MIN};
    end else begin
      sat_coord = {1'b0, v[COORD_W-1:0]};
    end
  endfunction

endpackage

FILE: rtl/rotate_point_about_center_unit.sv
// Rotates a Q15.16 point about a Q15.16 center by a Q15.16 angle.
//
// Input stream (in_*): one transfer carries point_x, point_y, center_x,
// center_y and angle. Output stream (out_*): one transfer per input with
// rotated_x, rotated_y (saturated) in out_tdata and overflow in out_tuser.
// cfg_wr_en/cfg_wr_data set the angle unit (0 radians, 1 degrees); write it
// only while no transfer is in flight.
//
// Throughput: one transfer per cycle while the skid register is empty. Every
// stage is a register; the deepest logic is one 33x32 multiply (phase
// scaling, then the four offset products). Registered steps from input
// transfer to out_tvalid: scale, phase split, one per CORDIC stage, quadrant
// fold, products, sum/round, center add and saturate.
//
// Reset (rst_n low, synchronous) drops all in-flight items and sets the
// angle unit to radians. When the receiver stalls, the result moves into a
// one-entry skid register so the pipeline can still advance; with the
// skid register full, in_tready drops and the whole pipeline holds.
module rotate_point_about_center_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // point_x, point_y, center_x, center_y, angle (32 bits each, low to high)
  input  logic [rpac_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // rotated_x, rotated_y (32 bits each, low to high)
  output logic [rpac_pkg::OUT_DATA_W-1:0] out_tdata,
  // overflow
  output logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data
);
  import rpac_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic deg_r;
  logic en;

  // Input field slices
  logic signed [COORD_W-1:0] in_px, in_py, in_cx, in_cy, in_angle;

  // Stage A: phase product and offsets
  logic signed [32:0]  mul_k;
  logic signed [64:0]  phase_prod;
  logic                v_a_r;
  logic [39:0]         a_prod_r;
  rpac_geo_t           a_geo_r;

  // Stage B / CORDIC
  logic [31:0]               phase;
  logic [31:0]               shifted;
  logic [N:0]                vs_r;
  logic signed [31:0]        xs_r [N+1];
  logic signed [31:0]        ys_r [N+1];
  logic signed [31:0]        zs_r [N+1];
  rpac_geo_t                 geo_r [N+1];

  // Stage C: quadrant fold
  logic                      v_c_r;
  logic signed [31:0]        c_nxt, s_nxt;
  logic signed [31:0]        c_r, s_r;
  rpac_geo_t                 c_geo_r;

  // Stage D: products
  logic                      v_d_r;
  logic signed [PROD_W-1:0]  p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [COORD_W-1:0] d_cx_r, d_cy_r;

  // Stage E: rounded rotated offset
  logic                      v_e_r;
  logic signed [DOT_W-1:0]   dot_x, dot_y;
  logic signed [ROT_W-1:0]   e_rx_r, e_ry_r;
  logic signed [COORD_W-1:0] e_cx_r, e_cy_r;

  // Final: center add and saturate
  logic signed [COORD_W+4:0] sum_x, sum_y;
  logic [COORD_W:0]          sat_x, sat_y;
  rpac_res_t                 fin_res;

  // Output and skid registers
  logic                      out_v_r;
  logic                      skid_v_r;
  rpac_res_t                 out_res_r;
  rpac_res_t                 skid_res_r;

  // Angle unit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b0;
    end else if (cfg_wr_en) begin
      deg_r <= cfg_wr_data;
    end
  end

  // The pipeline advances whenever the skid register is free
  assign en        = !skid_v_r;
  assign in_tready = en;

  assign in_px    = in_tdata[31:0];
  assign in_py    = in_tdata[63:32];
  assign in_cx    = in_tdata[95:64];
  assign in_cy    = in_tdata[127:96];
  assign in_angle = in_tdata[159:128];

  // Stage A: scale the angle to a phase where 2^32 is one full turn
  assign mul_k      = deg_r ? $signed({1'b0, K_DEG}) : $signed({1'b0, K_RAD});
  assign phase_prod = in_angle * mul_k;

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r     <= phase_prod[55:16];
      a_geo_r.quad <= QUAD_0;
      a_geo_r.dx   <= {in_px[COORD_W-1], in_px} - {in_cx[COORD_W-1], in_cx};
      a_geo_r.dy   <= {in_py[COORD_W-1], in_py} - {in_cy[COORD_W-1], in_cy};
      a_geo_r.cx   <= in_cx;
      a_geo_r.cy   <= in_cy;
    end
  end

  // Stage B: split the phase into quarter turns and a residual of +-1/8 turn
  assign phase   = deg_r ? a_prod_r[39:8] : a_prod_r[31:0];
  assign shifted = phase + PHASE_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r[0]       <= CORDIC_X0;
      ys_r[0]       <= '0;
      zs_r[0]       <= $signed({2'b00, shifted[29:0]} - PHASE_BIAS);
      geo_r[0].quad <= shifted[31:30];
      geo_r[0].dx   <= a_geo_r.dx;
      geo_r[0].dy   <= a_geo_r.dy;
      geo_r[0].cx   <= a_geo_r.cx;
      geo_r[0].cy   <= a_geo_r.cy;
    end
  end

  // CORDIC rotation stages, one micro-rotation per register stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [31:0] x_sh, y_sh, atan_i;
    assign x_sh   = xs_r[i] >>> i;
    assign y_sh   = ys_r[i] >>> i;
    assign atan_i = $signed(ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs_r[i][31]) begin
          xs_r[i+1] <= xs_r[i] - y_sh;
          ys_r[i+1] <= ys_r[i] + x_sh;
          zs_r[i+1] <= zs_r[i] - atan_i;
        end else begin
          xs_r[i+1] <= xs_r[i] + y_sh;
          ys_r[i+1] <= ys_r[i] - x_sh;
          zs_r[i+1] <= zs_r[i] + atan_i;
        end
        geo_r[i+1] <= geo_r[i];
      end
    end
  end

  // Stage C: apply the whole quarter turns exactly
  always_comb begin
    unique case (geo_r[N].quad)
      QUAD_0: begin
        c_nxt = xs_r[N];
        s_nxt = ys_r[N];
      end
      QUAD_90: begin
        c_nxt = -ys_r[N];
        s_nxt = xs_r[N];
      end
      QUAD_180: begin
        c_nxt = -xs_r[N];
        s_nxt = -ys_r[N];
      end
      QUAD_270: begin
        c_nxt = ys_r[N];
        s_nxt = -xs_r[N];
      end
      default: begin
        c_nxt = xs_r[N];
        s_nxt = ys_r[N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r     <= c_nxt;
      s_r     <= s_nxt;
      c_geo_r <= geo_r[N];
    end
  end

  // Stage D: offset times cos/sin
  always_ff @(posedge clk) begin
    if (en) begin
      p_xc_r <= c_geo_r.dx * c_r;
      p_ys_r <= c_geo_r.dy * s_r;
      p_xs_r <= c_geo_r.dx * s_r;
      p_yc_r <= c_geo_r.dy * c_r;
      d_cx_r <= c_geo_r.cx;
      d_cy_r <= c_geo_r.cy;
    end
  end

  // Stage E: combine, round half up, drop 30 fraction bits
  assign dot_x = {p_xc_r[PROD_W-1], p_xc_r} - {p_ys_r[PROD_W-1], p_ys_r} + ROUND_HALF;
  assign dot_y = {p_xs_r[PROD_W-1], p_xs_r} + {p_yc_r[PROD_W-1], p_yc_r} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      e_rx_r <= dot_x[DOT_W-1:30];
      e_ry_r <= dot_y[DOT_W-1:30];
      e_cx_r <= d_cx_r;
      e_cy_r <= d_cy_r;
    end
  end

  // Add the center back and clamp
  assign sum_x = {e_rx_r[ROT_W-1], e_rx_r} + {{5{e_cx_r[COORD_W-1]}}, e_cx_r};
  assign sum_y = {e_ry_r[ROT_W-1], e_ry_r} + {{5{e_cy_r[COORD_W-1]}}, e_cy_r};
  assign sat_x = sat_coord(sum_x);
  assign sat_y = sat_coord(sum_y);

  assign fin_res.x   = sat_x[COORD_W-1:0];
  assign fin_res.y   = sat_y[COORD_W-1:0];
  assign fin_res.ovf = sat_x[COORD_W] | sat_y[COORD_W];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      vs_r  <= '0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_tvalid;
      vs_r  <= {vs_r[N-1:0], v_a_r};
      v_c_r <= vs_r[N];
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
    end
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= v_e_r;
    end else if (v_e_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_v_r || out_tready) begin
      out_res_r <= fin_res;
    end else begin
      skid_res_r <= fin_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.y, out_res_r.x};
  assign out_tuser  = out_res_r.ovf;

  // A parked result always sits behind a presented one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid without output valid");

  // A finished result arriving at a stalled output is parked, not dropped
  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && v_e_r && !skid_v_r) |=> skid_v_r)
    else $error("result lost on output stall");

  // Parked result stays parked until the output drains
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_tready) |=> (skid_v_r && $stable(skid_res_r)))
    else $error("skid entry changed during stall");

  // Overflow only with a clamped coordinate
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_res_r.x == SAT_MAX || out_res_r.x == SAT_MIN ||
       out_res_r.y == SAT_MAX || out_res_r.y == SAT_MIN))
    else $error("overflow flagged without saturated coordinate");

endmodule

FILE: dv/tb_rotate_point_about_center_unit.sv
module tb_rotate_point_about_center_unit;
  import rpac_pkg::*;

  // Base for the settling wait after the final drain
  localparam int LATENCY = CORDIC_STAGES + 5;
  // Cycles the receiver holds off once to fill the pipeline and skid register
  localparam int LONG_HOLD = 200;
  // Hard stop, well above the slowest legal run
  localparam int TIMEOUT = 5_000_000;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint HALF_LSB = 64'sd536870912;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
  } rotated_point_t;

  // Holds the expected rotated points in transfer order and checks each result
  class rotated_point_tracker;
    rotated_point_t expected_points[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // Rotate (px,py) about (cx,cy); phase split, CORDIC, quadrant fold, round, saturate
    function rotated_point_t rotate_about_center(logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] cx,
                                                 logic signed [31:0] cy,
                                                 logic signed [31:0] ang,
                                                 logic in_deg);
      longint prod, x, y, z, xs, ys, c, s, dx, dy, t, rx, ry;
      logic [31:0] phase, biased;
      logic [1:0] quad;
      int i, k;
      rotated_point_t res;
      if (in_deg) begin
        prod = longint'(ang) * longint'(K_DEG);
        phase = prod[55:24];
      end else begin
        prod = longint'(ang) * longint'(K_RAD);
        phase = prod[47:16];
      end
      biased = phase + PHASE_BIAS;
      quad = biased[31:30];
      z = longint'(biased[29:0]) - HALF_LSB;
      x = longint'(CORDIC_X0);
      y = 0;
      for (i = 0; i < CORDIC_STAGES; i++) begin
        k = i % 32;
        xs = x >>> k;
        ys = y >>> k;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ATAN_TURNS[k]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ATAN_TURNS[k]);
        end
      end
      case (quad)
        QUAD_90: begin
          c = -y;
          s = x;
        end
        QUAD_180: begin
          c = -x;
          s = -y;
        end
        QUAD_270: begin
          c = y;
          s = -x;
        end
        default: begin
          c = x;
          s = y;
        end
      endcase
      dx = longint'(px) - longint'(cx);
      dy = longint'(py) - longint'(cy);
      t = dx * c - dy * s;
      rx = ((t + HALF_LSB) >>> 30) + longint'(cx);
      t = dx * s + dy * c;
      ry = ((t + HALF_LSB) >>> 30) + longint'(cy);
      res.ovf = 1'b0;
      if (rx > COORD_MAX) begin
        rx = COORD_MAX;
        res.ovf = 1'b1;
      end else if (rx < COORD_MIN) begin
        rx = COORD_MIN;
        res.ovf = 1'b1;
      end
      if (ry > COORD_MAX) begin
        ry = COORD_MAX;
        res.ovf = 1'b1;
      end else if (ry < COORD_MIN) begin
        ry = COORD_MIN;
        res.ovf = 1'b1;
      end
      res.x = rx[31:0];
      res.y = ry[31:0];
      return res;
    endfunction

    function void note_input(logic [IN_DATA_W-1:0] d, logic in_deg);
      expected_points.push_back(rotate_about_center(d[31:0], d[63:32], d[95:64],
                                                    d[127:96], d[159:128], in_deg));
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic ovf);
      rotated_point_t exp_pt;
      if (expected_points.size() == 0) begin
        $error("result with nothing expected: rotated_x=%h rotated_y=%h overflow=%b",
               x, y, ovf);
        errors++;
        return;
      end
      exp_pt = expected_points.pop_front();
      if (x !== exp_pt.x) begin
        $error("rotated_x: expected %h, actual %h", exp_pt.x, x);
        errors++;
      end
      if (y !== exp_pt.y) begin
        $error("rotated_y: expected %h, actual %h", exp_pt.y, y);
        errors++;
      end
      if (ovf !== exp_pt.ovf) begin
        $error("overflow: expected %b, actual %b", exp_pt.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en;
  logic                  cfg_wr_data;

  // Angle unit the block currently holds; changes only while nothing is in flight
  logic angle_deg;
  // Random gaps on both sides when set; clear for back-to-back stretches
  bit   idle_on;
  // Ask the receiver for one long hold-off
  bit   hold_req;

  rotated_point_tracker tracker;

  rotate_point_about_center_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stop a hung run
  initial begin
    #(TIMEOUT);
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_point(logic [31:0] px, logic [31:0] py,
                                                      logic [31:0] cx, logic [31:0] cy,
                                                      logic [31:0] ang);
    return {ang, cy, cx, py, px};
  endfunction

  // Coordinates: mostly moderate, some full range, some at the rails
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 33554432)) - 32'd16777216;
      4, 5, 6:    return $urandom;
      7:          return S_MIN;
      8:          return S_MAX;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'd1;
          default: return ONE_Q16;
        endcase
      end
    endcase
  endfunction

  // Angles: full range, a few turns, near quarter turns in degrees (small angles in radians), and the extremes
  function automatic logic [31:0] rand_angle(logic in_deg);
    int quarter;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5, 6: begin
        if (in_deg) return 32'($urandom_range(0, 94371840)) - 32'd47185920;
        else return 32'($urandom_range(0, 1048576)) - 32'd524288;
      end
      7, 8: begin
        quarter = int'($urandom_range(0, 15)) - 8;
        if (in_deg)
          return 32'(quarter * 90 * 65536) + 32'($urandom_range(0, 2)) - 32'd1;
        else return 32'($urandom_range(0, 131072)) - 32'd65536;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'd0;
          1:       return S_MIN;
          2:       return S_MAX;
          3:       return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  // Offer one item after a random gap; hold it until the transfer happens
  task automatic send_item(logic [IN_DATA_W-1:0] d);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait for every expected result before touching the register
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic set_angle_unit(logic deg);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = deg;
    angle_deg   = deg;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
  endtask

  task automatic run_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_item(pack_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_angle(angle_deg)));
    end
  endtask

  // Record each input transfer with the angle unit in force
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.note_input(in_tdata, angle_deg);
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      tracker.check_result(out_tdata[31:0], out_tdata[63:32], out_tuser);
  end

  // Receiver: ready bursts and stalls; one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_tready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    tracker     = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    angle_deg   = 1'b0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Radians: zero, quarter turn, rails, angle wrap, zero angle with large offset
    set_angle_unit(1'b0);
    send_item(pack_point(32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_item(pack_point(ONE_Q16, 32'd0, 32'd0, 32'd0, 32'd102944));
    send_item(pack_point(S_MAX, S_MIN, S_MIN, S_MAX, 32'd0));
    send_item(pack_point(S_MIN, S_MAX, S_MAX, S_MIN, 32'd205887));
    send_item(pack_point(S_MAX, S_MAX, 32'd0, 32'd0, S_MAX));
    send_item(pack_point(S_MIN, S_MIN, 32'd0, 32'd0, S_MIN));
    send_item(pack_point(32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 32'hFFFE_0000,
                         32'hFFFF_3700));
    send_item(pack_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
    send_item(pack_point(32'd1, 32'd1, S_MAX, S_MIN, 32'd1));
    send_item(pack_point(S_MAX, 32'd0, S_MIN, 32'd0, 32'd0));
    send_item(pack_point(32'h4000_0000, 32'h4000_0000, 32'd0, 32'd0, 32'd51472));

    // Degrees: quarter turns, full turn, eighth turn, wrap extremes, overflow
    set_angle_unit(1'b1);
    send_item(pack_point(ONE_Q16, ONE_Q16, 32'd0, 32'd0, 32'h005A_0000));
    send_item(pack_point(ONE_Q16, 32'd0, 32'd0, 32'd0, 32'h00B4_0000));
    send_item(pack_point(ONE_Q16, 32'd0, 32'd0, 32'd0, 32'h010E_0000));
    send_item(pack_point(32'h0010_0000, 32'h0020_0000, ONE_Q16, ONE_Q16, 32'hFFA6_0000));
    send_item(pack_point(32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'h0168_0000));
    send_item(pack_point(32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'h002D_0000));
    send_item(pack_point(S_MAX, S_MAX, S_MIN, S_MIN, 32'h00B4_0000));
    send_item(pack_point(S_MIN, S_MAX, 32'd0, 32'd0, S_MAX));
    send_item(pack_point(S_MAX, S_MIN, 32'd0, 32'd0, S_MIN));
    send_item(pack_point(32'h7000_0000, 32'h7000_0000, 32'd0, 32'd0, 32'h002D_0000));

    // Random phases; the first one carries the long receiver hold-off
    set_angle_unit(1'b0);
    hold_req = 1'b1;
    run_random(300);
    set_angle_unit(1'b1);
    run_random(300);
    // Back-to-back on both sides
    set_angle_unit(1'b0);
    idle_on = 1'b0;
    run_random(150);
    set_angle_unit(1'b1);
    idle_on = 1'b1;
    run_random(200);

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (tracker.pending() != 0)
        $error("%0d expected results never arrived", tracker.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
